// File: rtl/udpdq_pkg.sv
// Package with operation codes, status codes, defaults and shared types of the UDP port demux.
`default_nettype none

package udpdq_pkg;

  // Default sizes of the port table, the rings and the buffer handles.
  localparam int PORT_SLOTS_DEF  = 16;
  localparam int RING_SLOTS_DEF  = 16;
  localparam int HANDLE_BITS_DEF = 12;

  // Fixed field widths.
  localparam int OP_BITS     = 2;
  localparam int PORT_BITS   = 16;
  localparam int STATUS_BITS = 3;

  // Operation codes.
  localparam logic [OP_BITS-1:0] OP_BIND    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_DELIVER = 2'd1;
  localparam logic [OP_BITS-1:0] OP_RECEIVE = 2'd2;

  // Status codes.
  localparam logic [STATUS_BITS-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_TABLE_FULL = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_NOT_BOUND  = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_QUEUE_FULL = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_NOT_UDP    = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY      = 3'd5;

  // Lookup and table status from the port match unit.
  typedef struct packed {
    logic found;
    logic table_full;
  } match_stat_t;

endpackage : udpdq_pkg

`default_nettype wire

// File: rtl/udpdq_port_match.sv
// Port table with bind logic and a registered parallel match followed by a priority encoder.
`default_nettype none

module udpdq_port_match #(
  parameter int PORT_SLOTS = udpdq_pkg::PORT_SLOTS_DEF,
  localparam int EntryBits = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           lookup_en,
  input  wire logic [udpdq_pkg::PORT_BITS-1:0] lookup_port,
  input  wire logic                           bind_en,
  input  wire logic [udpdq_pkg::PORT_BITS-1:0] bind_port,
  output logic      [EntryBits-1:0]           match_entry,
  output logic      [EntryBits-1:0]           bind_entry,
  output udpdq_pkg::match_stat_t              match_stat
);

  import udpdq_pkg::*;

  localparam int CountBits = $clog2(PORT_SLOTS + 1);

  logic [PORT_BITS-1:0]  bound_port_r [PORT_SLOTS];
  logic [CountBits-1:0]  count_r;
  logic [PORT_SLOTS-1:0] match_r;
  logic                  found;
  logic                  full;

  assign full       = (count_r == CountBits'(PORT_SLOTS));
  assign bind_entry = count_r[EntryBits-1:0];

  // Bound entry count; a bind takes the next free entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (bind_en) begin
      count_r <= count_r + CountBits'(1);
    end
  end

  // Port table write. Entries at or above the count never produce a hit.
  always_ff @(posedge clk) begin
    if (bind_en) begin
      bound_port_r[count_r[EntryBits-1:0]] <= bind_port;
    end
  end

  // Compare every bound entry at once and register the hit vector.
  always_ff @(posedge clk) begin
    if (lookup_en) begin
      for (int i = 0; i < PORT_SLOTS; i++) begin
        match_r[i] <= (CountBits'(i) < count_r) && (bound_port_r[i] == lookup_port);
      end
    end
  end

  // The lowest matching entry wins.
  always_comb begin
    found       = 1'b0;
    match_entry = '0;
    for (int i = PORT_SLOTS - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        found       = 1'b1;
        match_entry = EntryBits'(i);
      end
    end
  end

  assign match_stat.found      = found;
  assign match_stat.table_full = full;

  // The count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CountBits'(PORT_SLOTS))
    else $error("bound count beyond table size");

  // A bind is only requested while the table has room.
  a_bind_room: assert property (@(posedge clk) disable iff (!rst_n)
    bind_en |-> !full)
    else $error("bind into a full table");

  // A reported hit points at a matching entry.
  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    found |-> match_r[match_entry])
    else $error("encoder points at a non-matching entry");

endmodule : udpdq_port_match

`default_nettype wire

// File: rtl/udp_port_demux_queues_top.sv
// Top level of the UDP port demux: sequencer, pointer memory, ring memory and output register.
// Each item passes the match register, the pointer memory read, the ring memory read (only for
// a receive that dequeues) and the output register, which holds it while out_ready is low.
// Items are taken one at a time: a new item is not accepted until the last result is loaded.
// Reset clears the sequencer, the bound count and the output valid; the memories are not
// cleared, since a bind writes its pointer entry and only filled ring slots are read.
`default_nettype none

module udp_port_demux_queues_top #(
  parameter int PORT_SLOTS  = udpdq_pkg::PORT_SLOTS_DEF,
  parameter int RING_SLOTS  = udpdq_pkg::RING_SLOTS_DEF,
  parameter int HANDLE_BITS = udpdq_pkg::HANDLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [udpdq_pkg::OP_BITS-1:0]    in_operation,
  input  wire logic [udpdq_pkg::PORT_BITS-1:0]  in_port,
  input  wire logic                             in_is_udp,
  input  wire logic [HANDLE_BITS-1:0]           in_packet_handle,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [udpdq_pkg::STATUS_BITS-1:0]     out_status,
  output logic [HANDLE_BITS-1:0]                out_handle_out
);

  import udpdq_pkg::*;

  localparam int EntryBits = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
  localparam int RingBits  = $clog2(RING_SLOTS);
  localparam int AddrBits  = EntryBits + RingBits;
  localparam int RingDepth = PORT_SLOTS * (1 << RingBits);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_PTR  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  function automatic logic [RingBits-1:0] ring_next(input logic [RingBits-1:0] pos);
    ring_next = (pos == RingBits'(RING_SLOTS - 1)) ? '0 : pos + RingBits'(1);
  endfunction

  logic [2:0]             state_r;
  logic [2:0]             state_nxt;
  logic [OP_BITS-1:0]     op_r;
  logic [PORT_BITS-1:0]   port_r;
  logic                   udp_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic [EntryBits-1:0]   entry_r;
  logic                   found_r;
  logic [STATUS_BITS-1:0] res_status_r;
  logic [STATUS_BITS-1:0] res_status_nxt;
  logic [HANDLE_BITS-1:0] res_handle_r;
  logic [HANDLE_BITS-1:0] res_handle_nxt;
  logic                   out_valid_r;
  logic [STATUS_BITS-1:0] out_status_r;
  logic [HANDLE_BITS-1:0] out_handle_r;

  // Pointer memory: {head, tail} per table entry.
  logic [2*RingBits-1:0]  ptr_mem [PORT_SLOTS];
  logic [2*RingBits-1:0]  ptr_rd_r;
  logic                   ptr_re;
  logic                   ptr_we;
  logic [EntryBits-1:0]   ptr_waddr;
  logic [2*RingBits-1:0]  ptr_wdata;
  logic [RingBits-1:0]    ptr_head;
  logic [RingBits-1:0]    ptr_tail;

  // Ring memory: one row of slots per table entry.
  logic [HANDLE_BITS-1:0] ring_mem [RingDepth];
  logic [HANDLE_BITS-1:0] ring_rd_r;
  logic                   ring_re;
  logic                   ring_we;
  logic [AddrBits-1:0]    ring_raddr;
  logic [AddrBits-1:0]    ring_waddr;

  logic                   in_xfer;
  logic                   bind_en;
  logic                   go_rd;
  logic                   out_load;
  logic [EntryBits-1:0]   m_entry;
  logic [EntryBits-1:0]   m_bind_entry;
  match_stat_t            m_stat;

  assign in_ready       = (state_r == S_IDLE);
  assign in_xfer        = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_handle_out = out_handle_r;
  assign ptr_head       = ptr_rd_r[2*RingBits-1:RingBits];
  assign ptr_tail       = ptr_rd_r[RingBits-1:0];
  assign ptr_re         = (state_r == S_LOOK);
  assign out_load       = (state_r == S_DONE) && (!out_valid_r || out_ready);

  udpdq_port_match #(
    .PORT_SLOTS (PORT_SLOTS)
  ) u_match (
    .clk         (clk),
    .rst_n       (rst_n),
    .lookup_en   (in_xfer),
    .lookup_port (in_port),
    .bind_en     (bind_en),
    .bind_port   (port_r),
    .match_entry (m_entry),
    .bind_entry  (m_bind_entry),
    .match_stat  (m_stat)
  );

  // Capture the item on its input transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r     <= in_operation;
      port_r   <= in_port;
      udp_r    <= in_is_udp;
      handle_r <= in_packet_handle;
    end
  end

  // Hold the lookup result while the pointer read is in flight.
  always_ff @(posedge clk) begin
    if (state_r == S_LOOK) begin
      entry_r <= m_entry;
      found_r <= m_stat.found;
    end
  end

  // Pointer memory ports.
  always_ff @(posedge clk) begin
    if (ptr_re) begin
      ptr_rd_r <= ptr_mem[m_entry];
    end
    if (ptr_we) begin
      ptr_mem[ptr_waddr] <= ptr_wdata;
    end
  end

  // Ring memory ports.
  always_ff @(posedge clk) begin
    if (ring_re) begin
      ring_rd_r <= ring_mem[ring_raddr];
    end
    if (ring_we) begin
      ring_mem[ring_waddr] <= handle_r;
    end
  end

  // Decide the operation once the pointers are read, and update them.
  always_comb begin
    res_status_nxt = ST_OK;
    res_handle_nxt = '0;
    bind_en        = 1'b0;
    ptr_we         = 1'b0;
    ptr_waddr      = entry_r;
    ptr_wdata      = ptr_rd_r;
    ring_we        = 1'b0;
    ring_re        = 1'b0;
    ring_waddr     = {entry_r, ptr_tail};
    ring_raddr     = {entry_r, ptr_head};
    go_rd          = 1'b0;
    if (state_r == S_PTR) begin
      unique case (op_r)
        OP_BIND: begin
          if (m_stat.table_full) begin
            res_status_nxt = ST_TABLE_FULL;
          end else begin
            bind_en   = 1'b1;
            ptr_we    = 1'b1;
            ptr_waddr = m_bind_entry;
            ptr_wdata = '0;
          end
        end
        OP_DELIVER: begin
          if (!udp_r) begin
            res_status_nxt = ST_NOT_UDP;
            res_handle_nxt = handle_r;
          end else if (!found_r) begin
            res_status_nxt = ST_NOT_BOUND;
            res_handle_nxt = handle_r;
          end else if (ring_next(ptr_tail) == ptr_head) begin
            res_status_nxt = ST_QUEUE_FULL;
            res_handle_nxt = handle_r;
          end else begin
            ring_we   = 1'b1;
            ptr_we    = 1'b1;
            ptr_wdata = {ptr_head, ring_next(ptr_tail)};
          end
        end
        OP_RECEIVE: begin
          if (!found_r) begin
            res_status_nxt = ST_NOT_BOUND;
          end else if (ptr_head == ptr_tail) begin
            res_status_nxt = ST_EMPTY;
          end else begin
            ring_re   = 1'b1;
            ptr_we    = 1'b1;
            ptr_wdata = {ring_next(ptr_head), ptr_tail};
            go_rd     = 1'b1;
          end
        end
        default: begin
          res_status_nxt = ST_OK;
        end
      endcase
    end
  end

  // Result staging.
  always_ff @(posedge clk) begin
    if (state_r == S_PTR) begin
      res_status_r <= res_status_nxt;
      res_handle_r <= res_handle_nxt;
    end else if (state_r == S_RD) begin
      res_handle_r <= ring_rd_r;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) begin
        state_nxt = S_LOOK;
      end
      S_LOOK: state_nxt = S_PTR;
      S_PTR:  state_nxt = go_rd ? S_RD : S_DONE;
      S_RD:   state_nxt = S_DONE;
      S_DONE: if (out_load) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register; a waiting result is held until its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_handle_r <= res_handle_r;
    end
  end

  // A handle is never written into a full ring.
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    ring_we |-> (ring_next(ptr_tail) != ptr_head))
    else $error("ring write into a full ring");

  // A dequeue reads a non-empty ring and collects the data next cycle.
  a_deq_read: assert property (@(posedge clk) disable iff (!rst_n)
    ring_re |-> (ptr_head != ptr_tail) ##1 (state_r == S_RD))
    else $error("dequeue from an empty ring or lost read data");

  // A new result appears only from the final sequencer step.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result shown outside the final step");

endmodule : udp_port_demux_queues_top

`default_nettype wire
